// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL files that carry checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on clk, off while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check sampled on clk, live during reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/xbug_pkg.sv
// ----------------------------------------------------------------------------
// xbug_pkg
// Shared types, constants and the xorshift step for the bounded generator
// ----------------------------------------------------------------------------
package xbug_pkg;

	localparam logic [31:0] SEED_RESET = 32'd42067420;
	localparam int unsigned SHIFT_A = 13;
	localparam int unsigned SHIFT_B = 17;
	localparam int unsigned SHIFT_C = 5;
	localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

	typedef logic [1:0] res_sel_t;
	localparam res_sel_t RES_LO  = 2'd0;
	localparam res_sel_t RES_RAW = 2'd1;
	localparam res_sel_t RES_SUM = 2'd2;

	localparam logic DIV_THR = 1'b0;
	localparam logic DIV_RAW = 1'b1;

	typedef struct packed {
		logic     seed_load;
		logic     load_req;
		logic     load_range;
		logic     div_start;
		logic     div_sel;
		logic     div_step;
		logic     draw;
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic range_one;
		logic range_zero;
		logic div_last;
		logic below_thr;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] next_word(input logic [31:0] w);
		logic [31:0] x;
		x = w;
		x = x ^ (x << SHIFT_A);
		x = x ^ (x >> SHIFT_B);
		x = x ^ (x << SHIFT_C);
		return x;
	endfunction

endpackage

// File: rtl/xbug_dp.sv
// ----------------------------------------------------------------------------
// xbug_dp
// Datapath: bound registers, xorshift word, shared bit-serial remainder
// unit and the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xbug_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  xbug_pkg::cmd_t     cmd,
	output xbug_pkg::sts_t     sts,
	input  logic               func,
	input  logic [31:0]        low_bound,
	input  logic [31:0]        high_bound,
	input  logic [31:0]        cfg_data,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [31:0]        value
);

	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic [31:0] range_q;
	logic [31:0] gen_q;
	logic [31:0] raw_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;
	logic [31:0] value_q;

	logic [31:0] bias;
	logic        swap;
	logic [31:0] gen_next;
	logic [32:0] trial;
	logic        ge;
	logic [32:0] diff;
	logic [31:0] res;

	assign bias     = func ? 32'd0 : xbug_pkg::SIGN_BIAS;
	assign swap     = (low_bound ^ bias) > (high_bound ^ bias);
	assign gen_next = xbug_pkg::next_word(gen_q);
	assign trial    = {rem_q, dvd_q[31]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = trial >= {1'b0, dvs_q};

	always_comb begin
		case (cmd.res_sel)
			xbug_pkg::RES_LO:  res = lo_q;
			xbug_pkg::RES_RAW: res = raw_q;
			xbug_pkg::RES_SUM: res = lo_q + rem_q;
			default:           res = lo_q;
		endcase
	end

	// request registers, raw draw, remainder unit and output value register
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			lo_q <= swap ? high_bound : low_bound;
			hi_q <= swap ? low_bound : high_bound;
		end
		if (cmd.load_range) begin
			range_q <= hi_q - lo_q + 32'd1;
		end
		if (cmd.draw) begin
			raw_q <= gen_next;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			dvs_q <= range_q;
			dvd_q <= (cmd.div_sel == xbug_pkg::DIV_RAW) ? raw_q : (32'd0 - range_q);
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
		if (cmd.out_load) begin
			value_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= xbug_pkg::SEED_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_load) begin
				gen_q <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
			end else if (cmd.draw) begin
				gen_q <= gen_next;
			end
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.range_one  = (range_q == 32'd1);
	assign sts.range_zero = (range_q == 32'd0);
	assign sts.div_last   = (cnt_q == 5'd31);
	assign sts.below_thr  = (raw_q < rem_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign value     = value_q;

	`ASSERT_ALWAYS(a_gen_nonzero, arst_n |-> (gen_q != 32'd0), "generator word reached zero")
	`ASSERT_CLK(a_rem_bounded, (cmd.div_step && sts.div_last) |=> (rem_q < dvs_q),
		"remainder not below divisor")

endmodule

// File: rtl/xbug_ctrl.sv
// ----------------------------------------------------------------------------
// xbug_ctrl
// Controller: sequences setup, threshold remainder, draw loop, final
// remainder and result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xbug_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  xbug_pkg::sts_t     sts,
	output xbug_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_CLASS = 3'd2;
	localparam logic [2:0] ST_THR   = 3'd3;
	localparam logic [2:0] ST_DRAW  = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;
	localparam logic [2:0] ST_MOD   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic                full_q;
	logic                full_d;
	xbug_pkg::res_sel_t  sel_q;
	xbug_pkg::res_sel_t  sel_d;

	always_comb begin
		state_d = state_q;
		full_d  = full_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.res_sel   = sel_q;
		cmd.seed_load = cfg_valid && (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.load_range = 1'b1;
				state_d        = ST_CLASS;
			end
			ST_CLASS: begin
				if (sts.range_one) begin
					sel_d   = xbug_pkg::RES_LO;
					state_d = ST_FIN;
				end else if (sts.range_zero) begin
					full_d  = 1'b1;
					state_d = ST_DRAW;
				end else begin
					full_d        = 1'b0;
					cmd.div_start = 1'b1;
					cmd.div_sel   = xbug_pkg::DIV_THR;
					state_d       = ST_THR;
				end
			end
			ST_THR: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				cmd.draw = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				if (full_q) begin
					sel_d   = xbug_pkg::RES_RAW;
					state_d = ST_FIN;
				end else if (sts.below_thr) begin
					state_d = ST_DRAW;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = xbug_pkg::DIV_RAW;
					state_d       = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					sel_d   = xbug_pkg::RES_SUM;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			full_q  <= 1'b0;
			sel_q   <= xbug_pkg::RES_LO;
		end else begin
			state_q <= state_d;
			full_q  <= full_d;
			sel_q   <= sel_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	`ASSERT_CLK(a_load_free, cmd.out_load |-> sts.out_free, "result loaded over a waiting result")
	`ASSERT_CLK(a_thr_to_draw, (state_q == ST_THR && sts.div_last) |=> (state_q == ST_DRAW),
		"threshold remainder did not lead to a draw")

endmodule

// File: rtl/xorshift_bounded_uniform_generator_core.sv
// ----------------------------------------------------------------------------
// xorshift_bounded_uniform_generator_core
// Uniform integer in an inclusive signed or unsigned range, drawn from a
// 13/17/5 xorshift source with rejection of biased draws
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    func, low_bound, high_bound
//  out      out  out_valid/out_stall  value
//  cfg      in   cfg_valid/cfg_ready  cfg_data (seed)
//
//  a general request runs setup, the threshold remainder, a draw and a check
//  per draw (each rejected draw is followed by another), the final
//  remainder and the hand-off, which waits while an earlier result is stalled
//  equal bounds skip both remainders and give low_bound; the full range gives the raw draw
//  reset loads seed 42067420; the seed is written only while idle
//  a new request is taken while a result waits under out_stall
// ----------------------------------------------------------------------------
module xorshift_bounded_uniform_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] low_bound,
	input  logic [31:0] high_bound,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	xbug_pkg::cmd_t cmd;
	xbug_pkg::sts_t sts;

	xbug_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	xbug_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.value      (value)
	);

endmodule

// File: tb/tb_xorshift_bounded_uniform_generator_core.sv
// ----------------------------------------------------------------------------
// tb_xorshift_bounded_uniform_generator_core
// Drives bounded uniform requests through the xorshift core: a directed table
// of range edge cases, then random requests across several seed settings.
// Each accepted request is predicted by a local copy of the generator state,
// and every delivered value is checked in order against those predictions, or
// against a row's fixed value, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_xorshift_bounded_uniform_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] RESET_SEED = 32'd42067420;
	localparam logic [31:0] SIGNED_FLIP = 32'h8000_0000;
	localparam int unsigned XS_LEFT_A = 13;
	localparam int unsigned XS_RIGHT_B = 17;
	localparam int unsigned XS_LEFT_C = 5;
	localparam logic MODE_SIGNED = 1'b0;
	localparam logic MODE_UNSIGNED = 1'b1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int HOLD_AFTER_RESULTS = 120;
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic        mode;
		logic [31:0] bound_a;
		logic [31:0] bound_b;
		bit          has_exp;
		logic [31:0] exp_value;
	} req_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [31:0] low_bound = '0;
	logic [31:0] high_bound = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	logic [31:0] gen_word = RESET_SEED;
	logic [31:0] pending_values [$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	bit          hold_done = 1'b0;

	req_row_t directed_rows [22] = '{
		'{MODE_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{MODE_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{MODE_SIGNED,   32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
		'{MODE_SIGNED,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
		'{MODE_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
		'{MODE_SIGNED,   32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
		'{MODE_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'h0000_0005, 32'h0000_0003, 1'b0, 32'h0},
		'{MODE_SIGNED,   32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
		'{MODE_SIGNED,   32'h8000_0000, 32'h8000_0001, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0},
		'{MODE_SIGNED,   32'hC000_0000, 32'h4000_0000, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'h1234_5678, 32'h1234_56DB, 1'b0, 32'h0},
		'{MODE_SIGNED,   32'hFFFF_FFF0, 32'h0000_0010, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{MODE_SIGNED,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{MODE_UNSIGNED, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0}
	};

	xorshift_bounded_uniform_generator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] step_generator();
		logic [31:0] x;
		x = gen_word;
		x = x ^ (x << XS_LEFT_A);
		x = x ^ (x >> XS_RIGHT_B);
		x = x ^ (x << XS_LEFT_C);
		gen_word = x;
		return x;
	endfunction

	function automatic logic [31:0] bounded_draw(input logic mode, input logic [31:0] a,
			input logic [31:0] b);
		logic [31:0] lo, hi, flip, span, thr, raw;
		flip = (mode == MODE_UNSIGNED) ? 32'h0 : SIGNED_FLIP;
		lo = a;
		hi = b;
		if ((lo ^ flip) > (hi ^ flip)) begin
			lo = b;
			hi = a;
		end
		span = hi - lo + 32'd1;
		if (span == 32'd1)
			return lo;
		if (span == 32'd0)
			return step_generator();
		thr = (32'd0 - span) % span;
		do begin
			raw = step_generator();
		end while (raw < thr);
		return lo + (raw % span);
	endfunction

	task automatic send_request(input logic mode, input logic [31:0] a, input logic [31:0] b,
			input bit has_exp, input logic [31:0] exp_value);
		logic [31:0] predicted;
		in_valid <= 1'b1;
		func <= mode;
		low_bound <= a;
		high_bound <= b;
		do @(posedge clk); while (in_stall);
		predicted = bounded_draw(mode, a, b);
		pending_values.push_back(has_exp ? exp_value : predicted);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(120, 1);
			burst_left = $urandom_range(12, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic random_request();
		logic        mode;
		logic [31:0] a, b, t;
		int          kind, k;
		mode = 1'($urandom_range(1, 0));
		a = $urandom;
		b = $urandom;
		kind = $urandom_range(99, 0);
		if (kind < 8) begin
			b = a;
		end else if (kind < 14) begin
			a = (mode == MODE_UNSIGNED) ? 32'h0000_0000 : 32'h8000_0000;
			b = (mode == MODE_UNSIGNED) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
		end else if (kind < 40) begin
			b = a + $urandom_range(20, 1);
		end else if (kind < 55) begin
			b = a + 32'h8000_0000 + $urandom_range(255, 0);
		end else if (kind < 65) begin
			k = $urandom_range(31, 1);
			b = a + ((32'd1 << k) - 32'd1);
		end else if (kind < 75) begin
			case ($urandom_range(3, 0))
				0: a = 32'h0000_0000;
				1: a = 32'hFFFF_FFFF;
				2: a = 32'h8000_0000;
				default: a = 32'h7FFF_FFFF;
			endcase
			if ($urandom_range(1, 0))
				b = ~a;
		end
		if ($urandom_range(1, 0)) begin
			t = a;
			a = b;
			b = t;
		end
		send_request(mode, a, b, 1'b0, 32'h0);
		pace();
	endtask

	task automatic run_random(input int count);
		repeat (count) random_request();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_values.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] seed_value);
		cfg_valid <= 1'b1;
		cfg_data <= seed_value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_word = (seed_value == 32'd0) ? 32'd1 : seed_value;
	endtask

	task automatic note_mismatch(input logic [31:0] exp_value, input logic [31:0] act_value);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("value mismatch: expected %h actual %h", exp_value, act_value);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen = results_seen + 1;
			if (pending_values.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result with no request pending: value %h", value);
			end else begin
				logic [31:0] exp_value;
				exp_value = pending_values.pop_front();
				if (value !== exp_value)
					note_mismatch(exp_value, value);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("xorshift_bounded_uniform_generator_core test failed");
				$finish;
			end
		end
	end

	// receiver: random stall segments, one long hold to back up the request side
	initial begin
		int seg_len;
		int mode;
		@(posedge arst_n);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				seg_len = $urandom_range(300, 10);
				mode = $urandom_range(3, 0);
				repeat (seg_len) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(99, 0) < 25);
						2: out_stall <= ($urandom_range(99, 0) < 75);
						default: out_stall <= 1'($urandom_range(1, 0));
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].mode, directed_rows[i].bound_a,
				directed_rows[i].bound_b, directed_rows[i].has_exp,
				directed_rows[i].exp_value);
			pace();
		end
		wait_idle();
		write_seed(32'h0000_0000);
		run_random(150);
		wait_idle();
		write_seed(32'hFFFF_FFFF);
		run_random(150);
		wait_idle();
		write_seed($urandom);
		run_random(175);
		wait_idle();
		write_seed($urandom);
		run_random(175);
		wait_idle();
		if (pending_values.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("xorshift_bounded_uniform_generator_core test passed");
		else
			$display("xorshift_bounded_uniform_generator_core test failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/xbug_pkg.sv
rtl/xbug_dp.sv
rtl/xbug_ctrl.sv
rtl/xorshift_bounded_uniform_generator_core.sv
tb/tb_xorshift_bounded_uniform_generator_core.sv
